// File: src/iirdf1_pkg.sv
`default_nettype none

package iirdf1_pkg;

  // Defaults for the top-level parameters
  localparam int ORDER_DEF       = 20;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COEF_BITS_DEF   = 32;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 5;
  localparam int CVAL_W  = 32;
  localparam int YH_W    = 32;   // output history, signed Q24.8
  localparam int CODE_W  = 12;
  localparam int DAC_W   = 14;
  localparam int OUT_TDATA_W = 32;

  // Q.32 accumulator down to Q24.8
  localparam int FRAC_DROP = 24;
  // Integer sample moved up to Q.8
  localparam int X_SHIFT   = 8;

  localparam logic [DAC_W-CODE_W-1:0] DAC_PREFIX = 2'b11;
  localparam logic [CODE_W-1:0]       CODE_MAX   = 12'hFFF;

  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd2;

  // Sequencer program counter
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_NUM    = 3'd1;
  localparam logic [PC_W-1:0] PC_DEN    = 3'd2;
  localparam logic [PC_W-1:0] PC_DRAIN0 = 3'd3;
  localparam logic [PC_W-1:0] PC_DRAIN1 = 3'd4;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd5;

  // Jump taken when the condition holds, else the step repeats
  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_TAP_LAST,
    JC_FILTER,
    JC_OUT_FREE
  } jcond_e;

  typedef struct packed {
    logic            ready;   // take an input beat
    logic            issue;   // read a tap and start a MAC
    logic            den;     // denominator tap
    logic            push;    // update histories, load result
    jcond_e          cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{ready: 1'b0, issue: 1'b0, den: 1'b0, push: 1'b0,
          cond: JC_ALWAYS, target: PC_WAIT};
    unique case (pc)
      PC_WAIT: begin
        c.ready  = 1'b1;
        c.cond   = JC_FILTER;
        c.target = PC_NUM;
      end
      PC_NUM: begin
        c.issue  = 1'b1;
        c.cond   = JC_TAP_LAST;
        c.target = PC_DEN;
      end
      PC_DEN: begin
        c.issue  = 1'b1;
        c.den    = 1'b1;
        c.cond   = JC_TAP_LAST;
        c.target = PC_DRAIN0;
      end
      PC_DRAIN0: begin
        c.target = PC_DRAIN1;
      end
      PC_DRAIN1: begin
        c.target = PC_FINISH;
      end
      PC_FINISH: begin
        c.push   = 1'b1;
        c.cond   = JC_OUT_FREE;
        c.target = PC_WAIT;
      end
      default: begin
        c.target = PC_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/iir_direct_form_one_filter.sv
`default_nettype none
// Filter beat: steps NUM, DEN, DRAIN0, DRAIN1, FINISH; the result loads at FINISH once
// the output is free. The single shared MAC does ORDER+1 numerator and ORDER denominator
// taps plus pipeline drain, so input waits until WAIT. Load beats: one per cycle in WAIT.
// Input is taken while a finished result waits in the output register.
// Reset (rst_ni low, async) clears the sequencer, valid bits and history fill count;
// coefficients and histories then read as zero until written.

module iir_direct_form_one_filter #(
  parameter int  ORDER       = iirdf1_pkg::ORDER_DEF,
  parameter int  SAMPLE_BITS = iirdf1_pkg::SAMPLE_BITS_DEF,
  parameter int  COEF_BITS   = iirdf1_pkg::COEF_BITS_DEF,
  localparam int IN_TDATA_W  =
    ((iirdf1_pkg::IDX_W + iirdf1_pkg::CVAL_W + SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // coef_index, coef_value, sample (from bit 0 up), zero padded
  input  wire logic [IN_TDATA_W-1:0]              s_axis_tdata_i,
  // cmd
  input  wire logic [iirdf1_pkg::CMD_W-1:0]       s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // dac_word, out_code (from bit 0 up), zero padded
  output logic [iirdf1_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // saturated
  output logic                                    m_axis_tuser_o
);

  import iirdf1_pkg::*;

  localparam int K_W    = $clog2(ORDER + 1);
  localparam int HA_W   = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int OPA_W  = YH_W + 1;
  localparam int PROD_W = OPA_W + COEF_BITS;
  localparam int ACC_W0 = PROD_W + $clog2(2 * ORDER + 2);
  localparam int ACC_W  = (ACC_W0 > 64) ? ACC_W0 : 64;
  localparam int SH_W   = ACC_W - FRAC_DROP;

  // ---------------- input fields
  logic [IDX_W-1:0]        in_idx;
  logic signed [CVAL_W-1:0] in_cval;
  logic [SAMPLE_BITS-1:0]  in_sample;
  logic [CMD_W-1:0]        in_cmd;

  assign in_idx    = s_axis_tdata_i[IDX_W-1:0];
  assign in_cval   = s_axis_tdata_i[IDX_W+CVAL_W-1:IDX_W];
  assign in_sample = s_axis_tdata_i[IDX_W+CVAL_W+SAMPLE_BITS-1:IDX_W+CVAL_W];
  assign in_cmd    = s_axis_tuser_i;

  // ---------------- sequencer
  ctrl_t           ctrl;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [K_W-1:0]  k_q, k_d;
  logic [HA_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [HA_W-1:0] head_q, head_inc;
  logic [K_W-1:0]  fill_q;
  logic            in_acc, tap_last, out_free, jump_ok, push;
  logic            idx_ok, load_b, load_a;

  assign ctrl            = ucode(pc_q);
  assign s_axis_tready_o = ctrl.ready;
  assign in_acc          = s_axis_tvalid_i && ctrl.ready;
  assign tap_last        = (k_q == K_W'(ORDER));
  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;

  always_comb begin
    unique case (ctrl.cond)
      JC_ALWAYS:   jump_ok = 1'b1;
      JC_TAP_LAST: jump_ok = tap_last;
      JC_FILTER:   jump_ok = in_acc && (in_cmd == CMD_FILTER);
      JC_OUT_FREE: jump_ok = out_free;
      default:     jump_ok = 1'b1;
    endcase
  end

  assign pc_d = jump_ok ? ctrl.target : pc_q;
  assign push = ctrl.push && jump_ok;

  assign head_inc = (head_q == HA_W'(ORDER - 1)) ? '0 : HA_W'(head_q + HA_W'(1));

  always_comb begin
    k_d = k_q;
    if (ctrl.issue) begin
      if (tap_last) begin
        k_d = ctrl.den ? '0 : K_W'(1);
      end else begin
        k_d = K_W'(k_q + K_W'(1));
      end
    end
  end

  // Walks newest to oldest; numerator tap 0 is the live sample and reads nothing
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (!ctrl.issue || (!ctrl.den && tap_last)) begin
      rd_ptr_d = head_q;
    end else if (ctrl.den || (k_q != '0)) begin
      rd_ptr_d = (rd_ptr_q == '0) ? HA_W'(ORDER - 1) : HA_W'(rd_ptr_q - HA_W'(1));
    end
  end

  assign idx_ok = (32'(in_idx) <= 32'(ORDER));
  assign load_b = in_acc && (in_cmd == CMD_LOAD_B) && idx_ok;
  assign load_a = in_acc && (in_cmd == CMD_LOAD_A) && idx_ok;

  logic [ORDER:0] b_vld_q, a_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= PC_WAIT;
      k_q      <= '0;
      rd_ptr_q <= '0;
      head_q   <= '0;
      fill_q   <= '0;
      b_vld_q  <= '0;
      a_vld_q  <= '0;
    end else begin
      pc_q     <= pc_d;
      k_q      <= k_d;
      rd_ptr_q <= rd_ptr_d;
      if (push) begin
        head_q <= head_inc;
        if (fill_q != K_W'(ORDER)) begin
          fill_q <= K_W'(fill_q + K_W'(1));
        end
      end
      if (load_b) begin
        b_vld_q[K_W'(in_idx)] <= 1'b1;
      end
      if (load_a) begin
        a_vld_q[K_W'(in_idx)] <= 1'b1;
      end
    end
  end

  // ---------------- stores
  logic [COEF_BITS-1:0]   coef_wdata;
  logic [COEF_BITS-1:0]   b_rdata, a_rdata;
  logic [SAMPLE_BITS-1:0] x_rdata;
  logic [YH_W-1:0]        y_rdata;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [YH_W-1:0]        y0;

  assign coef_wdata = COEF_BITS'(in_cval);

  iirdf1_ram #(.WIDTH(COEF_BITS), .DEPTH(ORDER + 1)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (load_b),
    .waddr_i (K_W'(in_idx)),
    .wdata_i (coef_wdata),
    .raddr_i (k_q),
    .rdata_o (b_rdata)
  );

  iirdf1_ram #(.WIDTH(COEF_BITS), .DEPTH(ORDER + 1)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (load_a),
    .waddr_i (K_W'(in_idx)),
    .wdata_i (coef_wdata),
    .raddr_i (k_q),
    .rdata_o (a_rdata)
  );

  iirdf1_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(ORDER)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (head_inc),
    .wdata_i (sample_q),
    .raddr_i (rd_ptr_q),
    .rdata_o (x_rdata)
  );

  iirdf1_ram #(.WIDTH(YH_W), .DEPTH(ORDER)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (head_inc),
    .wdata_i (y0),
    .raddr_i (rd_ptr_q),
    .rdata_o (y_rdata)
  );

  // ---------------- MAC pipeline: read, multiply, accumulate
  logic s1_vld_q, s1_den_q, s1_smp_q, s1_zero_q;
  logic s2_vld_q, s2_den_q;
  logic coef_ok, hist_ok;

  assign coef_ok = ctrl.den ? a_vld_q[k_q] : b_vld_q[k_q];
  assign hist_ok = (k_q <= fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= ctrl.issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_den_q  <= ctrl.den;
    s1_smp_q  <= (k_q == '0);
    s1_zero_q <= !(coef_ok && ((k_q == '0) || hist_ok));
    s2_den_q  <= s1_den_q;
    if (in_acc && (in_cmd == CMD_FILTER)) begin
      sample_q <= in_sample;
    end
  end

  logic signed [OPA_W-1:0]     opa;
  logic signed [COEF_BITS-1:0] opb;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     acc_q, acc_d, prod_ext;

  always_comb begin
    if (s1_zero_q) begin
      opa = '0;
      opb = '0;
    end else if (s1_den_q) begin
      opa = OPA_W'(signed'(y_rdata));
      opb = signed'(a_rdata);
    end else begin
      opa = s1_smp_q ? OPA_W'({sample_q, X_SHIFT'(0)}) : OPA_W'({x_rdata, X_SHIFT'(0)});
      opb = signed'(b_rdata);
    end
  end

  assign prod_ext = ACC_W'(prod_q);
  assign acc_d    = s2_den_q ? (acc_q - prod_ext) : (acc_q + prod_ext);

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    if (in_acc && (in_cmd == CMD_FILTER)) begin
      acc_q <= '0;
    end else if (s2_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // ---------------- Q.32 -> Q24.8, saturate, output code
  logic signed [SH_W-1:0] sh;
  logic                   y_fits;
  logic [CODE_W-1:0]      code;
  logic                   sat;

  assign sh     = SH_W'(acc_q >>> FRAC_DROP);
  assign y_fits = (&sh[SH_W-1:YH_W-1]) || !(|sh[SH_W-1:YH_W-1]);
  assign y0     = y_fits ? sh[YH_W-1:0]
                         : (sh[SH_W-1] ? {1'b1, {(YH_W-1){1'b0}}} : {1'b0, {(YH_W-1){1'b1}}});

  always_comb begin
    if (y0[YH_W-1]) begin
      code = '0;
      sat  = 1'b1;
    end else if (|y0[YH_W-2:X_SHIFT+CODE_W]) begin
      code = CODE_MAX;
      sat  = 1'b1;
    end else begin
      code = y0[X_SHIFT+CODE_W-1:X_SHIFT];
      sat  = 1'b0;
    end
  end

  // ---------------- output register
  logic              out_vld_q;
  logic [CODE_W-1:0] out_code_q;
  logic              out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_code_q <= code;
      out_sat_q  <= sat;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_code_q, DAC_PREFIX, out_code_q});
  assign m_axis_tuser_o  = out_sat_q;

endmodule

`default_nettype wire

// File: src/iirdf1_ram.sv
`default_nettype none

module iirdf1_ram #(
  parameter int  WIDTH  = 32,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
